>>> rtl/omrm_pkg.sv
// Shared types, constants and helper functions for the register machine.
package omrm_pkg;

    localparam int NUM_REGS    = 4;
    localparam int REG_WIDTH   = 32;
    localparam int IDX_W       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int FIELD_W     = 32;
    localparam int OUT_REGS    = 4;
    localparam int OP_MAP_W    = 64;
    localparam logic [OP_MAP_W-1:0] OP_MAP_RESET = 64'hFEDC_BA98_7654_3210;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = OUT_REGS * FIELD_W;

    // Input request layout inside tdata
    localparam int OPN_LSB  = 0;
    localparam int OPA_LSB  = 4;
    localparam int OPB_LSB  = 36;
    localparam int DEST_LSB = 68;

    typedef logic [REG_WIDTH-1:0]               t_reg;
    typedef logic [NUM_REGS-1:0][REG_WIDTH-1:0] t_regfile;
    typedef logic [IDX_W-1:0]                   t_idx;

    typedef enum logic [3:0] {
        OP_ADDR = 4'd0,
        OP_ADDI = 4'd1,
        OP_MULR = 4'd2,
        OP_MULI = 4'd3,
        OP_BANR = 4'd4,
        OP_BANI = 4'd5,
        OP_BORR = 4'd6,
        OP_BORI = 4'd7,
        OP_SETR = 4'd8,
        OP_SETI = 4'd9,
        OP_GTIR = 4'd10,
        OP_GTRI = 4'd11,
        OP_GTRR = 4'd12,
        OP_EQIR = 4'd13,
        OP_EQRI = 4'd14,
        OP_EQRR = 4'd15
    } t_op;

    typedef struct packed {
        logic ok;
        t_idx wr_idx;
        t_reg value;
    } t_exec_res;

    // Truncate or zero-extend a 32-bit field to register width
    function automatic t_reg field_to_reg(input logic [FIELD_W-1:0] v);
        logic [REG_WIDTH+FIELD_W-1:0] w;
        w = {{REG_WIDTH{1'b0}}, v};
        return w[REG_WIDTH-1:0];
    endfunction

    // Truncate or zero-extend a register to the 32-bit output field
    function automatic logic [FIELD_W-1:0] reg_to_field(input t_reg v);
        logic [REG_WIDTH+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, v};
        return w[FIELD_W-1:0];
    endfunction

    // Register index bits of a field already checked to be in range
    function automatic t_idx field_to_idx(input logic [FIELD_W-1:0] v);
        return v[IDX_W-1:0];
    endfunction

endpackage

>>> rtl/omrm_exec.sv
// Operand decode, index check and ALU for one instruction.
module omrm_exec
    import omrm_pkg::*;
(
    input  t_op                i_op,
    input  logic [FIELD_W-1:0] i_opa,
    input  logic [FIELD_W-1:0] i_opb,
    input  logic [1:0]         i_dest,
    input  t_regfile           i_regs,
    output t_exec_res          o_res
);

    logic               a_reg;
    logic               b_reg;
    logic [FIELD_W-1:0] dest_w;
    t_reg               va;
    t_reg               vb;
    t_reg               alu;

    // Decide which operands name registers
    always_comb begin
        unique case (i_op) inside
            OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTRR, OP_EQRR: begin
                a_reg = 1'b1;
                b_reg = 1'b1;
            end
            OP_GTIR, OP_EQIR: begin
                a_reg = 1'b0;
                b_reg = 1'b1;
            end
            OP_SETI: begin
                a_reg = 1'b0;
                b_reg = 1'b0;
            end
            default: begin
                a_reg = 1'b1;
                b_reg = 1'b0;
            end
        endcase
    end

    assign dest_w = {{(FIELD_W-2){1'b0}}, i_dest};

    // Fetch operand values
    assign va = a_reg ? i_regs[field_to_idx(i_opa)] : field_to_reg(i_opa);
    assign vb = b_reg ? i_regs[field_to_idx(i_opb)] : field_to_reg(i_opb);

    // Execute
    always_comb begin
        case (i_op) inside
            OP_ADDR, OP_ADDI:          alu = va + vb;
            OP_MULR, OP_MULI:          alu = va * vb;
            OP_BANR, OP_BANI:          alu = va & vb;
            OP_BORR, OP_BORI:          alu = va | vb;
            OP_SETR, OP_SETI:          alu = va;
            OP_GTIR, OP_GTRI, OP_GTRR: alu = field_to_reg({31'd0, va > vb});
            default:                   alu = field_to_reg({31'd0, va == vb});
        endcase
    end

    // Reject any register index that is out of range
    assign o_res.ok = (dest_w < FIELD_W'(NUM_REGS))
                    && (!a_reg || (i_opa < FIELD_W'(NUM_REGS)))
                    && (!b_reg || (i_opb < FIELD_W'(NUM_REGS)));
    assign o_res.wr_idx = field_to_idx(dest_w);
    assign o_res.value  = alu;

endmodule

>>> rtl/opcode_mapped_register_machine_unit.sv
// Top level of the opcode-mapped four-register ALU machine.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  s       | in        | i_s_tvalid/o_s_tready  | op_number, operand_a, operand_b, dest
//  m       | out       | o_m_tvalid/i_m_tready  | reg_zero..reg_three; tuser bad_index
//  cfg     | in        | i_cfg_we               | op_map (64 bits)
//
// One instruction per cycle while the result side accepts; a request passes through the
// input register, then the execute stage writes the register file and the result
// register in the same cycle.
// Reset clears the register file, valid flags and restores the identity op_map.
// A stalled result holds the execute stage; the input register still takes
// one more request while the result waits.
module opcode_mapped_register_machine_unit
    import omrm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [3:0] op_number, [35:4] operand_a, [67:36] operand_b, [69:68] dest_reg, [71:70] zero
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [31:0] reg_zero, [63:32] reg_one, [95:64] reg_two, [127:96] reg_three
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // [0] bad_index
    output logic [0:0]           o_m_tuser,
    input  logic                 i_cfg_we,
    input  logic [OP_MAP_W-1:0]  i_cfg_wdata
);

    logic [OP_MAP_W-1:0]  r_op_map;
    logic                 r_in_valid;
    logic [3:0]           r_opn;
    logic [FIELD_W-1:0]   r_opa;
    logic [FIELD_W-1:0]   r_opb;
    logic [1:0]           r_dest;
    t_regfile             r_regs;
    t_regfile             n_regs;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TDATA_W-1:0] n_out_data;
    logic                 r_out_bad;
    logic                 exec_go;
    logic                 in_take;
    t_op                  op;
    t_exec_res            res;

    assign exec_go    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || exec_go;
    assign in_take    = i_s_tvalid && o_s_tready;

    // Translate the opcode number through the map
    assign op = t_op'(r_op_map[{r_opn, 2'b00} +: 4]);

    omrm_exec u_exec (
        .i_op   (op),
        .i_opa  (r_opa),
        .i_opb  (r_opb),
        .i_dest (r_dest),
        .i_regs (r_regs),
        .o_res  (res)
    );

    // Next register file after this instruction
    always_comb begin
        n_regs = r_regs;
        if (res.ok) begin
            n_regs[res.wr_idx] = res.value;
        end
    end

    // Pack the four visible registers
    always_comb begin
        n_out_data = '0;
        for (int i = 0; i < OUT_REGS; i++) begin
            if (i < NUM_REGS) begin
                n_out_data[i*FIELD_W +: FIELD_W] = reg_to_field(n_regs[i]);
            end
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_map <= OP_MAP_RESET;
        end else if (i_cfg_we) begin
            r_op_map <= i_cfg_wdata;
        end
    end

    // Input register: hold a request until execute takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_opn  <= i_s_tdata[OPN_LSB  +: 4];
            r_opa  <= i_s_tdata[OPA_LSB  +: FIELD_W];
            r_opb  <= i_s_tdata[OPB_LSB  +: FIELD_W];
            r_dest <= i_s_tdata[DEST_LSB +: 2];
        end
    end

    // Register file: advance on each executed instruction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else if (exec_go) begin
            r_regs <= n_regs;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_out_data <= n_out_data;
            r_out_bad  <= !res.ok;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_bad;

endmodule

>>> verif/tb_opcode_mapped_register_machine_unit.sv
// Self-checking testbench for the opcode-mapped register machine: directed and random.
module tb_opcode_mapped_register_machine_unit;
    import omrm_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DIRECTED_N    = 25;
    localparam int PHASE_N       = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int HOLD_OFF_LEN  = 300;

    // Register snapshot carried by one result request
    typedef struct packed {
        logic [FIELD_W-1:0] r0;
        logic [FIELD_W-1:0] r1;
        logic [FIELD_W-1:0] r2;
        logic [FIELD_W-1:0] r3;
        logic               bad;
    } t_reg_snapshot;

    // One directed instruction; the snapshot is used only where typed is set
    typedef struct packed {
        t_op           op;
        logic [31:0]   a;
        logic [31:0]   b;
        logic [1:0]    dest;
        logic          typed;
        t_reg_snapshot want;
    } t_directed_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // [3:0] op_number, [35:4] operand_a, [67:36] operand_b, [69:68] dest_reg, [71:70] zero
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // [31:0] reg_zero, [63:32] reg_one, [95:64] reg_two, [127:96] reg_three
    logic [M_TDATA_W-1:0] o_m_tdata;
    // [0] bad_index
    logic [0:0]           o_m_tuser;
    logic                 i_cfg_we = 1'b0;
    logic [OP_MAP_W-1:0]  i_cfg_wdata = '0;

    // Machine state as the checker sees it
    t_reg                 regs_model [NUM_REGS];
    logic [OP_MAP_W-1:0]  op_map_model = OP_MAP_RESET;
    t_reg_snapshot        snapshots_due [$];
    t_reg_snapshot        oldest_snapshot;

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  burst_left     = 0;
    bit  sender_gaps_on = 1'b1;
    int  hold_off_asks  = 0;

    // Directed instructions, run under the identity map left by reset
    t_directed_row directed_rows [DIRECTED_N] = '{
        '{OP_SETI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd0, 1'b1,
          '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0}},
        '{OP_SETI, 32'h1234_5678, 32'h0000_0000, 2'd3, 1'b1,
          '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1234_5678, 1'b0}},
        '{OP_ADDI, 32'h0000_0000, 32'h0000_0002, 2'd1, 1'b1,
          '{32'hFFFF_FFFF, 32'h1, 32'h0, 32'h1234_5678, 1'b0}},
        // bad register indexes: nothing changes
        '{OP_ADDR, 32'h0000_0004, 32'h0000_0000, 2'd2, 1'b1,
          '{32'hFFFF_FFFF, 32'h1, 32'h0, 32'h1234_5678, 1'b1}},
        '{OP_MULR, 32'h0000_0000, 32'hFFFF_FFFF, 2'd2, 1'b1,
          '{32'hFFFF_FFFF, 32'h1, 32'h0, 32'h1234_5678, 1'b1}},
        '{OP_SETR, 32'hFFFF_FFFF, 32'h0000_0000, 2'd0, 1'b1,
          '{32'hFFFF_FFFF, 32'h1, 32'h0, 32'h1234_5678, 1'b1}},
        '{OP_GTIR, 32'hFFFF_FFFF, 32'h0000_0005, 2'd0, 1'b1,
          '{32'hFFFF_FFFF, 32'h1, 32'h0, 32'h1234_5678, 1'b1}},
        '{OP_EQRI, 32'h8000_0000, 32'h0000_0000, 2'd1, 1'b1,
          '{32'hFFFF_FFFF, 32'h1, 32'h0, 32'h1234_5678, 1'b1}},
        // unused operand is never checked as an index
        '{OP_SETR, 32'h0000_0003, 32'hFFFF_FFFF, 2'd2, 1'b1,
          '{32'hFFFF_FFFF, 32'h1, 32'h1234_5678, 32'h1234_5678, 1'b0}},
        '{OP_MULI, 32'h0000_0000, 32'hFFFF_FFFF, 2'd1, 1'b0, '0},
        '{OP_MULR, 32'h0000_0003, 32'h0000_0002, 2'd2, 1'b0, '0},
        '{OP_ADDR, 32'h0000_0000, 32'h0000_0000, 2'd3, 1'b0, '0},
        '{OP_BANR, 32'h0000_0002, 32'h0000_0003, 2'd1, 1'b0, '0},
        '{OP_BANI, 32'h0000_0000, 32'hF0F0_F0F0, 2'd2, 1'b0, '0},
        '{OP_BORR, 32'h0000_0001, 32'h0000_0002, 2'd0, 1'b0, '0},
        '{OP_BORI, 32'h0000_0003, 32'h0000_FFFF, 2'd3, 1'b0, '0},
        '{OP_GTIR, 32'hFFFF_FFFF, 32'h0000_0001, 2'd1, 1'b0, '0},
        '{OP_GTRI, 32'h0000_0000, 32'hFFFF_FFFE, 2'd2, 1'b0, '0},
        '{OP_GTRR, 32'h0000_0002, 32'h0000_0002, 2'd0, 1'b0, '0},
        '{OP_EQIR, 32'h0000_0000, 32'h0000_0001, 2'd3, 1'b0, '0},
        '{OP_EQRI, 32'h0000_0003, 32'h0000_0000, 2'd1, 1'b0, '0},
        '{OP_EQRR, 32'h0000_0001, 32'h0000_0001, 2'd2, 1'b0, '0},
        '{OP_SETI, 32'h0000_0000, 32'h0000_0000, 2'd0, 1'b0, '0},
        '{OP_SETI, 32'h8000_0000, 32'hFFFF_FFFF, 2'd3, 1'b0, '0},
        '{OP_ADDI, 32'h0000_0003, 32'hFFFF_FFFF, 2'd3, 1'b0, '0}
    };

    opcode_mapped_register_machine_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Generate the clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Classify the operands of an operation as register index or immediate
    function automatic void operand_kinds(input t_op op, output bit a_reg, output bit b_reg);
        case (op)
            OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTRR, OP_EQRR: begin
                a_reg = 1'b1; b_reg = 1'b1;
            end
            OP_GTIR, OP_EQIR: begin
                a_reg = 1'b0; b_reg = 1'b1;
            end
            OP_SETI: begin
                a_reg = 1'b0; b_reg = 1'b0;
            end
            default: begin
                a_reg = 1'b1; b_reg = 1'b0;
            end
        endcase
    endfunction

    // Execute one instruction on the register model and return the snapshot
    function automatic t_reg_snapshot run_instruction(input logic [3:0] opn,
                                                      input logic [31:0] a, b,
                                                      input logic [1:0] dest);
        t_op           op;
        bit            a_reg, b_reg, ok;
        t_reg          va, vb, res;
        t_reg_snapshot snap;
        op = t_op'(op_map_model[4*opn +: 4]);
        operand_kinds(op, a_reg, b_reg);
        ok = (int'(dest) < NUM_REGS) && (!a_reg || a < 32'(NUM_REGS))
             && (!b_reg || b < 32'(NUM_REGS));
        if (ok) begin
            va = a_reg ? regs_model[a[IDX_W-1:0]] : t_reg'(a);
            vb = b_reg ? regs_model[b[IDX_W-1:0]] : t_reg'(b);
            case (op)
                OP_ADDR, OP_ADDI:          res = va + vb;
                OP_MULR, OP_MULI:          res = va * vb;
                OP_BANR, OP_BANI:          res = va & vb;
                OP_BORR, OP_BORI:          res = va | vb;
                OP_SETR, OP_SETI:          res = va;
                OP_GTIR, OP_GTRI, OP_GTRR: res = (va > vb) ? t_reg'(1) : t_reg'(0);
                default:                   res = (va == vb) ? t_reg'(1) : t_reg'(0);
            endcase
            regs_model[dest[IDX_W-1:0]] = res;
        end
        snap.r0  = regs_model[0];
        snap.r1  = regs_model[1];
        snap.r2  = regs_model[2];
        snap.r3  = regs_model[3];
        snap.bad = !ok;
        return snap;
    endfunction

    // Register index, now and then out of range
    function automatic logic [31:0] pick_index();
        case ($urandom_range(0, 19))
            17:      return 32'($urandom_range(NUM_REGS, 15));
            18:      return $urandom;
            19:      return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(0, NUM_REGS - 1));
        endcase
    endfunction

    // Immediate, mostly full-width random with some small and edge values
    function automatic logic [31:0] pick_immediate();
        case ($urandom_range(0, 9))
            0, 1: return 32'($urandom_range(0, 15));
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h0000_0000;
                    1:       return 32'hFFFF_FFFF;
                    2:       return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Report a field that differs from its expectation
    function automatic void check_field(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    // Offer one instruction request, with a random gap between bursts when sender gaps are on
    task automatic send_instruction(input logic [3:0] opn, input logic [31:0] a, b,
                                    input logic [1:0] dest, input bit typed,
                                    input t_reg_snapshot typed_want);
        t_reg_snapshot predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (sender_gaps_on) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, dest, b, a, opn};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predicted = run_instruction(opn, a, b, dest);
        snapshots_due = {snapshots_due, (typed ? typed_want : predicted)};
    endtask

    // Random instruction whose operands suit the mapped operation
    task automatic send_random_instruction();
        logic [3:0]  opn;
        logic [31:0] a, b;
        bit          a_reg, b_reg;
        opn = 4'($urandom_range(0, 15));
        operand_kinds(t_op'(op_map_model[4*opn +: 4]), a_reg, b_reg);
        a = a_reg ? pick_index() : pick_immediate();
        b = b_reg ? pick_index() : pick_immediate();
        send_instruction(opn, a, b, 2'($urandom_range(0, 3)), 1'b0, '0);
    endtask

    // Drop the input, wait for every result, then let the pipeline settle
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (snapshots_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the opcode map while the machine is idle
    task automatic write_op_map(input logic [OP_MAP_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        op_map_model = value;
        i_cfg_we    <= 1'b0;
    endtask

    // Main stimulus: reset, directed table, then random phases under several maps
    initial begin : stimulus
        int                  n;
        int                  ph;
        logic [OP_MAP_W-1:0] map_value;
        for (n = 0; n < NUM_REGS; n++) regs_model[n] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < DIRECTED_N; n++)
            send_instruction(directed_rows[n].op, directed_rows[n].a, directed_rows[n].b,
                             directed_rows[n].dest, directed_rows[n].typed,
                             directed_rows[n].want);

        for (ph = 0; ph < PHASE_N; ph++) begin
            case (ph)
                0:       map_value = 64'h0123_4567_89AB_CDEF;
                1:       map_value = 64'h0000_0000_0000_0000;
                2:       map_value = 64'hFFFF_FFFF_FFFF_FFFF;
                3:       map_value = 64'h9898_9898_9898_9898;
                7:       map_value = OP_MAP_RESET;
                default: map_value = {$urandom, $urandom};
            endcase
            write_op_map(map_value);
            sender_gaps_on = (ph % 3) != 2;
            // stall the result side for a long stretch while requests keep coming
            if (ph == 1 || ph == 5) hold_off_asks++;
            for (n = 0; n < PHASE_ITEMS; n++) send_random_instruction();
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Drive result ready: changing stall patterns plus requested long hold-offs
    initial begin : receiver
        int mode_left;
        int rx_mode;
        int hold_left;
        int served;
        bit ready_next;
        mode_left = 0;
        rx_mode   = 0;
        hold_left = 0;
        served    = 0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode_left = $urandom_range(20, 200);
                rx_mode   = $urandom_range(0, 2);
            end
            mode_left--;
            if (hold_left == 0 && served != hold_off_asks) begin
                served++;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                case (rx_mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = $urandom_range(0, 1);
                    default: ready_next = ($urandom_range(0, 7) == 0);
                endcase
            end
            i_m_tready <= ready_next;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (snapshots_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with no expectation, expected none actual %h %h",
                         $time, o_m_tdata, o_m_tuser);
            end else begin
                oldest_snapshot = snapshots_due.pop_front();
                check_field("reg_zero",  oldest_snapshot.r0, o_m_tdata[0*FIELD_W +: FIELD_W]);
                check_field("reg_one",   oldest_snapshot.r1, o_m_tdata[1*FIELD_W +: FIELD_W]);
                check_field("reg_two",   oldest_snapshot.r2, o_m_tdata[2*FIELD_W +: FIELD_W]);
                check_field("reg_three", oldest_snapshot.r3, o_m_tdata[3*FIELD_W +: FIELD_W]);
                check_field("bad_index", 32'(oldest_snapshot.bad), 32'(o_m_tuser[0]));
            end
        end
    end

    // End a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, snapshots_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

>>> files.f
rtl/omrm_pkg.sv
rtl/omrm_exec.sv
rtl/opcode_mapped_register_machine_unit.sv
verif/tb_opcode_mapped_register_machine_unit.sv
